// ----- design/pulse_meter_energy_power_assert.svh -----
// Assertion macros for the impulse meter
`ifndef PULSE_METER_ENERGY_POWER_ASSERT_SVH
`define PULSE_METER_ENERGY_POWER_ASSERT_SVH

// same-cycle implication
`define PME_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("pme assertion failed");

// next-cycle implication
`define PME_ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pme assertion failed");

`endif

// ----- design/pme_pkg.sv -----
package pme_pkg;

  localparam int unsigned DATA_W    = 32;
  localparam int unsigned DEB_W     = 16;
  localparam int unsigned CFG_IDX_W = 4;
  localparam int unsigned DIV_CNT_W = 5;

  typedef logic [DATA_W-1:0]    data_t;
  typedef logic [DEB_W-1:0]     deb_t;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  typedef logic [DIV_CNT_W-1:0] div_cnt_t;

  localparam logic CMD_TICK    = 1'b0;
  localparam logic CMD_TRIGGER = 1'b1;

  localparam cfg_idx_t REG_DEBOUNCE = cfg_idx_t'(0);
  localparam cfg_idx_t REG_SCALE    = cfg_idx_t'(1);

  localparam deb_t  DEBOUNCE_RESET = deb_t'(10);
  localparam data_t SCALE_RESET    = data_t'(3600 * 1000 * 100);
  localparam data_t DATA_MAX       = '1;

  localparam div_cnt_t DIV_LAST = '1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIV,
    S_DONE
  } state_t;

  typedef struct packed {
    logic tick;
    logic start;
    logic step;
    logic load_out;
  } ctrl_cmd_t;

  typedef struct packed {
    logic is_tick;
    logic hit;
    logic div_last;
  } dp_status_t;

endpackage

// ----- design/pme_if.sv -----
interface pme_in_if;
  logic valid;
  logic ready;
  logic command;
  logic comparator_high;

  modport source (output valid, command, comparator_high, input ready);
  modport sink   (input valid, command, comparator_high, output ready);
endinterface

interface pme_out_if;
  logic           valid;
  logic           ready;
  pme_pkg::data_t energy_wh;
  pme_pkg::data_t power_centiwatts;
  pme_pkg::data_t interval_ms;

  modport source (output valid, energy_wh, power_centiwatts, interval_ms, input ready);
  modport sink   (input valid, energy_wh, power_centiwatts, interval_ms, output ready);
endinterface

interface pme_cfg_if;
  logic              valid;
  logic              ready;
  pme_pkg::cfg_idx_t index;
  pme_pkg::data_t    data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ----- design/pme_ctrl.sv -----
`include "pulse_meter_energy_power_assert.svh"

module pme_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  pme_pkg::dp_status_t st,
  output pme_pkg::ctrl_cmd_t  cmd
);

  pme_pkg::state_t state, state_next;
  logic            out_valid_next;
  logic            accept;

  assign accept = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= pme_pkg::S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      pme_pkg::S_IDLE: begin
        if (accept && st.hit) state_next = pme_pkg::S_DIV;
      end
      pme_pkg::S_DIV: begin
        if (st.div_last) state_next = pme_pkg::S_DONE;
      end
      pme_pkg::S_DONE: begin
        if (!out_valid || out_ready) state_next = pme_pkg::S_IDLE;
      end
      default: state_next = pme_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    in_ready     = (state == pme_pkg::S_IDLE);
    cmd.tick     = accept && st.is_tick;
    cmd.start    = accept && st.hit;
    cmd.step     = (state == pme_pkg::S_DIV);
    cmd.load_out = (state == pme_pkg::S_DONE) && (!out_valid || out_ready);
    out_valid_next = cmd.load_out || (out_valid && !out_ready);
  end

  `PME_ASSERT_NXT(a_start_div, clk, rst, accept && st.hit, state == pme_pkg::S_DIV)
  `PME_ASSERT_NXT(a_div_runs, clk, rst, (state == pme_pkg::S_DIV) && !st.div_last, state == pme_pkg::S_DIV)
  `PME_ASSERT_NXT(a_div_ends, clk, rst, (state == pme_pkg::S_DIV) && st.div_last, state == pme_pkg::S_DONE)
  `PME_ASSERT_NXT(a_done_waits, clk, rst, (state == pme_pkg::S_DONE) && out_valid && !out_ready, state == pme_pkg::S_DONE)
  `PME_ASSERT_IMP(a_no_tick_and_hit, clk, rst, cmd.tick, !cmd.start)

endmodule

// ----- design/pme_dp.sv -----
module pme_dp (
  input  logic                 clk,
  input  logic                 rst,
  input  pme_pkg::ctrl_cmd_t   cmd,
  output pme_pkg::dp_status_t  st,
  input  logic                 command,
  input  logic                 comparator_high,
  input  logic                 cfg_we,
  input  pme_pkg::cfg_idx_t    cfg_index,
  input  pme_pkg::data_t       cfg_data,
  output pme_pkg::data_t       energy_wh,
  output pme_pkg::data_t       power_centiwatts,
  output pme_pkg::data_t       interval_ms
);

  pme_pkg::deb_t     debounce_ms;
  pme_pkg::data_t    power_scale;
  pme_pkg::data_t    pulse_total;
  pme_pkg::data_t    elapsed_ms;
  pme_pkg::data_t    divisor;
  pme_pkg::data_t    quot;
  pme_pkg::data_t    rem;
  pme_pkg::div_cnt_t count;

  logic [pme_pkg::DATA_W:0]   rem_shift;
  logic [pme_pkg::DATA_W+1:0] diff;
  logic                       ge;
  logic                       debounced;

  assign debounced = (elapsed_ms >= {{(pme_pkg::DATA_W - pme_pkg::DEB_W){1'b0}}, debounce_ms});

  always_comb begin
    st.is_tick  = (command == pme_pkg::CMD_TICK);
    st.hit      = (command == pme_pkg::CMD_TRIGGER) && !comparator_high && debounced;
    st.div_last = (count == pme_pkg::DIV_LAST);
  end

  // restoring divider, one quotient bit per step; a zero divisor yields all ones
  assign rem_shift = {rem, quot[pme_pkg::DATA_W-1]};
  assign diff      = {1'b0, rem_shift} - {2'b00, divisor};
  assign ge        = !diff[pme_pkg::DATA_W+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_ms <= pme_pkg::DEBOUNCE_RESET;
      power_scale <= pme_pkg::SCALE_RESET;
    end else if (cfg_we) begin
      if (cfg_index == pme_pkg::REG_DEBOUNCE) begin
        debounce_ms <= cfg_data[pme_pkg::DEB_W-1:0];
      end else if (cfg_index == pme_pkg::REG_SCALE) begin
        power_scale <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pulse_total <= '0;
      elapsed_ms  <= '0;
    end else if (cmd.start) begin
      pulse_total <= pulse_total + pme_pkg::data_t'(1);
      elapsed_ms  <= '0;
    end else if (cmd.tick && (elapsed_ms != pme_pkg::DATA_MAX)) begin
      elapsed_ms <= elapsed_ms + pme_pkg::data_t'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      divisor <= elapsed_ms;
      quot    <= power_scale;
      rem     <= '0;
      count   <= '0;
    end else if (cmd.step) begin
      quot  <= {quot[pme_pkg::DATA_W-2:0], ge};
      rem   <= ge ? diff[pme_pkg::DATA_W-1:0] : rem_shift[pme_pkg::DATA_W-1:0];
      count <= count + pme_pkg::div_cnt_t'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      energy_wh        <= pulse_total;
      power_centiwatts <= quot;
      interval_ms      <= divisor;
    end
  end

endmodule

// ----- design/pulse_meter_energy_power.sv -----
// Flow: a counted trigger is taken into the divider, which runs one step per
// quotient bit; the result is then loaded out and offered; output stalls delay it.
// Ticks and ignored triggers are taken while the meter is idle; after a counted
// trigger the next input beat waits until the result has been loaded out.
// Reset (rst, synchronous, active high): pulse total and elapsed time clear,
// debounce_ms returns to 10, power_scale to 360000000, no result pending.
module pulse_meter_energy_power (
  input  logic      clk,
  input  logic      rst,
  pme_in_if.sink    in_ch,
  pme_out_if.source out_ch,
  pme_cfg_if.sink   cfg
);

  pme_pkg::ctrl_cmd_t  cmd;
  pme_pkg::dp_status_t st;

  assign cfg.ready = 1'b1;

  pme_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .st        (st),
    .cmd       (cmd)
  );

  pme_dp u_dp (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .st               (st),
    .command          (in_ch.command),
    .comparator_high  (in_ch.comparator_high),
    .cfg_we           (cfg.valid),
    .cfg_index        (cfg.index),
    .cfg_data         (cfg.data),
    .energy_wh        (out_ch.energy_wh),
    .power_centiwatts (out_ch.power_centiwatts),
    .interval_ms      (out_ch.interval_ms)
  );

endmodule

// ----- test/pulse_meter_energy_power_tb.sv -----
`timescale 1ns / 1ps

typedef struct packed {
  pme_pkg::data_t energy;
  pme_pkg::data_t power;
  pme_pkg::data_t interval;
} meter_reading_t;

class meter_scoreboard;
  pme_pkg::deb_t  debounce;
  pme_pkg::data_t scale;
  pme_pkg::data_t total;
  pme_pkg::data_t elapsed;
  meter_reading_t readings_due[$];
  int             faults;

  function new();
    debounce = pme_pkg::DEBOUNCE_RESET;
    scale    = pme_pkg::SCALE_RESET;
    total    = '0;
    elapsed  = '0;
    faults   = 0;
  endfunction

  function void apply_register(pme_pkg::cfg_idx_t idx, pme_pkg::data_t val);
    if (idx == pme_pkg::REG_DEBOUNCE) begin
      debounce = pme_pkg::deb_t'(val);
    end else if (idx == pme_pkg::REG_SCALE) begin
      scale = val;
    end
  endfunction

  // tracks elapsed time and queues a reading for each counted pulse
  function void accept_input(logic cmd, logic level_high);
    meter_reading_t r;
    if (cmd == pme_pkg::CMD_TICK) begin
      if (elapsed != pme_pkg::DATA_MAX) elapsed = elapsed + pme_pkg::data_t'(1);
      return;
    end
    if (level_high || elapsed < pme_pkg::data_t'(debounce)) return;
    r.interval = elapsed;
    elapsed    = '0;
    total      = total + pme_pkg::data_t'(1);
    r.energy   = total;
    r.power    = (r.interval == '0) ? pme_pkg::DATA_MAX : scale / r.interval;
    readings_due.push_back(r);
  endfunction

  function void note_fault(string msg);
    faults++;
    if (faults <= 10) $display("%t %s", $realtime, msg);
  endfunction

  function void check_field(string name, pme_pkg::data_t want, pme_pkg::data_t got);
    if (want !== got)
      note_fault($sformatf("%s mismatch: expected %0d (0x%h), got %0d (0x%h)",
                           name, want, want, got, got));
  endfunction

  function void check_reading(pme_pkg::data_t energy, pme_pkg::data_t power,
                              pme_pkg::data_t interval);
    meter_reading_t want;
    if (readings_due.size() == 0) begin
      note_fault($sformatf("unexpected beat: energy %0d power %0d interval %0d",
                           energy, power, interval));
      return;
    end
    want = readings_due.pop_front();
    check_field("energy_wh", want.energy, energy);
    check_field("power_centiwatts", want.power, power);
    check_field("interval_ms", want.interval, interval);
  endfunction

  function int pending();
    return readings_due.size();
  endfunction

  function void close_out();
    if (readings_due.size() != 0)
      note_fault($sformatf("%0d readings never arrived", readings_due.size()));
  endfunction
endclass

module pulse_meter_energy_power_tb;

  localparam int                STALL_LIMIT      = 5000;
  localparam int                SETTLE_CYCLES    = 40;
  localparam int                LONG_HOLD_CYCLES = 400;
  localparam int                ITEMS_PER_SET    = 160;
  localparam pme_pkg::cfg_idx_t REG_FIRST_UNUSED =
    pme_pkg::REG_SCALE + pme_pkg::cfg_idx_t'(1);
  localparam pme_pkg::cfg_idx_t REG_LAST_UNUSED  = '1;

  logic clk;
  logic rst;

  int tx_idle_pct;
  int rx_idle_pct;
  bit long_hold_req;

  meter_scoreboard sb;

  pme_in_if  in_ch();
  pme_out_if out_ch();
  pme_cfg_if cfg_ch();

  pulse_meter_energy_power dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg    (cfg_ch)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  task automatic send_item(logic cmd, logic level_high);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid           <= 1'b1;
    in_ch.command         <= cmd;
    in_ch.comparator_high <= level_high;
    do @(posedge clk); while (!in_ch.ready);
    sb.accept_input(cmd, level_high);
  endtask

  task automatic send_ticks(int n);
    repeat (n) send_item(pme_pkg::CMD_TICK, logic'($urandom_range(0, 1)));
  endtask

  // wait for every reading plus the tail of the divider
  task automatic settle();
    in_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(pme_pkg::cfg_idx_t idx, pme_pkg::data_t val);
    settle();
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    sb.apply_register(idx, val);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic random_config();
    pme_pkg::deb_t  deb;
    pme_pkg::data_t scale;
    if ($urandom_range(0, 3) == 0) deb = pme_pkg::deb_t'($urandom_range(0, 1));
    else deb = pme_pkg::deb_t'($urandom_range(2, 20));
    case ($urandom_range(0, 3))
      0: scale = pme_pkg::DATA_MAX;
      1: scale = pme_pkg::data_t'(1);
      2: scale = pme_pkg::data_t'($urandom);
      default: scale = pme_pkg::SCALE_RESET;
    endcase
    write_register(pme_pkg::REG_DEBOUNCE, {16'($urandom), deb});
    write_register(pme_pkg::REG_SCALE, scale);
    if ($urandom_range(0, 2) == 0)
      write_register(pme_pkg::cfg_idx_t'($urandom_range(REG_FIRST_UNUSED, REG_LAST_UNUSED)),
                     pme_pkg::data_t'($urandom));
  endtask

  // mostly tick runs around the debounce window ended by a trigger
  task automatic run_random(int n_items);
    int sent;
    int lo;
    int n;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(0, 9) < 8) begin
        lo = (sb.debounce > 3) ? int'(sb.debounce) - 3 : 0;
        n  = $urandom_range(lo, int'(sb.debounce) + 5);
        send_ticks(n);
        send_item(pme_pkg::CMD_TRIGGER, logic'($urandom_range(0, 4) == 0));
        sent += n + 1;
      end else begin
        send_item(logic'($urandom_range(0, 1)), logic'($urandom_range(0, 1)));
        sent++;
      end
    end
  endtask

  initial begin
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("DONE: errors detected");
    $finish;
  end

  // result side: random stalls plus one long hold-off
  initial begin
    int hold_left;
    bit hold_done;
    hold_left    = 0;
    hold_done    = 1'b0;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (out_ch.valid && out_ch.ready)
        sb.check_reading(out_ch.energy_wh, out_ch.power_centiwatts, out_ch.interval_ms);
      if (long_hold_req && !hold_done) begin
        hold_left = LONG_HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
      end
    end
  end

  initial begin
    sb                    = new();
    tx_idle_pct           = 0;
    rx_idle_pct           = 0;
    long_hold_req         = 1'b0;
    rst                   = 1'b1;
    in_ch.valid           = 1'b0;
    in_ch.command         = pme_pkg::CMD_TICK;
    in_ch.comparator_high = 1'b0;
    cfg_ch.valid          = 1'b0;
    cfg_ch.index          = pme_pkg::REG_DEBOUNCE;
    cfg_ch.data           = '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset settings: high level ignored, early trigger ignored, count at debounce
    send_item(pme_pkg::CMD_TRIGGER, 1'b1);
    send_item(pme_pkg::CMD_TRIGGER, 1'b0);
    send_ticks(9);
    send_item(pme_pkg::CMD_TRIGGER, 1'b0);
    send_item(pme_pkg::CMD_TICK, 1'b1);
    send_item(pme_pkg::CMD_TRIGGER, 1'b1);
    send_item(pme_pkg::CMD_TRIGGER, 1'b0);
    send_item(pme_pkg::CMD_TRIGGER, 1'b0);

    // zero debounce: zero interval, zero scale, unit and full scale
    write_register(REG_LAST_UNUSED, pme_pkg::DATA_MAX);
    write_register(REG_FIRST_UNUSED, '0);
    write_register(pme_pkg::REG_DEBOUNCE, {16'hFFFF, 16'h0000});
    write_register(pme_pkg::REG_SCALE, '0);
    send_item(pme_pkg::CMD_TRIGGER, 1'b0);
    send_item(pme_pkg::CMD_TICK, 1'b0);
    send_item(pme_pkg::CMD_TRIGGER, 1'b0);
    write_register(pme_pkg::REG_SCALE, pme_pkg::data_t'(1));
    send_ticks(2);
    send_item(pme_pkg::CMD_TRIGGER, 1'b0);
    send_item(pme_pkg::CMD_TICK, 1'b0);
    send_item(pme_pkg::CMD_TRIGGER, 1'b0);
    write_register(pme_pkg::REG_SCALE, pme_pkg::DATA_MAX);
    send_item(pme_pkg::CMD_TICK, 1'b1);
    send_item(pme_pkg::CMD_TRIGGER, 1'b0);

    for (int mode = 0; mode < 3; mode++) begin
      case (mode)
        0: begin
          tx_idle_pct = 33;
          rx_idle_pct = 53;
        end
        1: begin
          tx_idle_pct = 53;
          rx_idle_pct = 33;
        end
        default: begin
          tx_idle_pct = 0;
          rx_idle_pct = 0;
        end
      endcase
      for (int k = 0; k < 3; k++) begin
        random_config();
        if (mode == 0 && k == 0) begin
          write_register(pme_pkg::REG_DEBOUNCE, '0);
          long_hold_req <= 1'b1;
        end
        run_random(ITEMS_PER_SET);
      end
    end

    // widest debounce window holds a trigger off, a narrower one lets it count
    write_register(pme_pkg::REG_DEBOUNCE, pme_pkg::data_t'(16'hFFFF));
    write_register(pme_pkg::REG_SCALE, pme_pkg::DATA_MAX);
    send_ticks(30);
    send_item(pme_pkg::CMD_TRIGGER, 1'b0);
    write_register(pme_pkg::REG_DEBOUNCE, pme_pkg::data_t'(16'h0020));
    send_ticks(2);
    send_item(pme_pkg::CMD_TRIGGER, 1'b0);
    send_item(pme_pkg::CMD_TICK, 1'b0);
    send_item(pme_pkg::CMD_TRIGGER, 1'b1);
    send_item(pme_pkg::CMD_TRIGGER, 1'b0);

    settle();
    sb.close_out();
    if (sb.faults == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
